// ===== sv/psfu_pkg.sv =====
// Package with the constants, codes, result type and byte swap of the frame unpacker.
`default_nettype none
package psfu_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned BUF_W    = 44;
    localparam int unsigned HELD_W   = 6;
    localparam int unsigned TOTAL_W  = 7;
    localparam int unsigned WPOS_W   = 4;
    localparam int unsigned SLOTS    = 3;
    localparam int unsigned SLOT_W   = 2;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [INDEX_W-1:0] SAMPLES_PER_FRAME = 6'd40;
    localparam logic [WPOS_W-1:0]  TRAILER_POS       = 4'd15;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_TRAILER = 1'b1;

    localparam logic REG_LABEL_FIRST  = 1'b0;
    localparam logic REG_LABEL_SECOND = 1'b1;

    localparam logic [SAMPLE_W-1:0] LABEL_FIRST_RST  = 12'h000;
    localparam logic [SAMPLE_W-1:0] LABEL_SECOND_RST = 12'hfff;

    typedef struct packed {
        logic                item_kind;
        logic [SAMPLE_W-1:0] sample_value;
        logic [INDEX_W-1:0]  sample_index;
        logic                header_found;
        logic [INDEX_W-1:0]  header_start;
        logic [WORD_W-1:0]   frame_word;
        logic [CHAN_W-1:0]   channel_id;
        logic                frame_has_header;
    } t_result;

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
        swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage
`default_nettype wire

// ===== sv/psfu_if.sv =====
// Handshake interfaces for the raw bank words and the unpacked result words.
`default_nettype none
interface psfu_word_if;
    import psfu_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] raw_word;
    logic              bank_start;

    modport source (output valid, output raw_word, output bank_start, input ready);
    modport sink   (input valid, input raw_word, input bank_start, output ready);
endinterface

interface psfu_res_if;
    import psfu_pkg::*;
    logic                valid;
    logic                ready;
    logic                item_kind;
    logic [SAMPLE_W-1:0] sample_value;
    logic [INDEX_W-1:0]  sample_index;
    logic                header_found;
    logic [INDEX_W-1:0]  header_start;
    logic [WORD_W-1:0]   frame_word;
    logic [CHAN_W-1:0]   channel_id;
    logic                frame_has_header;
    logic                last;

    modport source (output valid, output item_kind, output sample_value, output sample_index,
                    output header_found, output header_start, output frame_word,
                    output channel_id, output frame_has_header, output last, input ready);
    modport sink   (input valid, input item_kind, input sample_value, input sample_index,
                    input header_found, input header_start, input frame_word,
                    input channel_id, input frame_has_header, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/packed_sample_frame_unpacker.sv =====
// Top level of the packed sample frame unpacker: input register, unpack logic and result buffer.
//
//   channel  | direction | word carries
//   ---------+-----------+-------------------------------------------------------------
//   i_in     | in        | raw_word, bank_start
//   o_out    | out       | item_kind, sample value/index, header flags, trailer, last
//   apb      | in/out    | label_first (0x0), label_second (0x4)
//
// A word is taken into the input register, unpacked into a buffer of up to three results,
// and these leave through the single result port one per cycle while the output is ready.
// A word is accepted while the buffer is still draining its last result. Reset is
// synchronous, clears framing and both stages and restores the label defaults.
// A stalled output holds its word and backs the input up through the input register.
`default_nettype none
module packed_sample_frame_unpacker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    psfu_word_if.sink                         i_in,
    psfu_res_if.source                        o_out,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [psfu_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [psfu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [psfu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import psfu_pkg::*;

    logic [SAMPLE_W-1:0] r_label_first;
    logic [SAMPLE_W-1:0] r_label_second;

    logic                r_in_valid;
    logic [WORD_W-1:0]   r_in_word;
    logic                r_in_start;

    logic [BUF_W-1:0]    r_buf,   n_buf;
    logic [HELD_W-1:0]   r_held,  n_held;
    logic [WPOS_W-1:0]   r_wpos,  n_wpos;
    logic [INDEX_W-1:0]  r_idx,   n_idx;
    logic                r_first, n_first;
    logic                r_hdr,   n_hdr;

    t_result             r_res [SLOTS];
    t_result             n_res [SLOTS];
    logic [SLOT_W-1:0]   r_cnt,   n_cnt;
    logic [SLOT_W-1:0]   r_sel;

    logic                out_fire;
    logic                load;
    logic                in_fire;
    logic                cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_LABEL_FIRST:  prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, r_label_first};
            REG_LABEL_SECOND: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, r_label_second};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_first  <= LABEL_FIRST_RST;
            r_label_second <= LABEL_SECOND_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_LABEL_FIRST) begin
                r_label_first <= pwdata[SAMPLE_W-1:0];
            end else begin
                r_label_second <= pwdata[SAMPLE_W-1:0];
            end
        end
    end

    // Handshakes.
    assign out_fire    = o_out.valid && o_out.ready;
    assign load        = r_in_valid && ((r_cnt == '0) || (r_cnt == 2'd1 && out_fire));
    assign i_in.ready  = !r_in_valid || load;
    assign in_fire     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_word  <= swap32(i_in.raw_word);
            r_in_start <= i_in.bank_start;
        end
    end

    // Unpacking of one word into up to three results.
    always_comb begin
        logic [BUF_W-1:0]   buf_e;
        logic [HELD_W-1:0]  held_e;
        logic [WPOS_W-1:0]  wpos_e;
        logic [INDEX_W-1:0] idx_e;
        logic               first_e;
        logic               hdr_e;
        logic [47:0]        wide;
        logic [BUF_W-1:0]   merged;
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] need;
        logic [TOTAL_W-1:0] pos;
        logic               ok;
        logic               found;
        logic [SAMPLE_W-1:0] s;
        logic [SLOT_W-1:0]  n;

        buf_e   = r_in_start ? '0 : r_buf;
        held_e  = r_in_start ? '0 : r_held;
        wpos_e  = r_in_start ? '0 : r_wpos;
        idx_e   = r_in_start ? '0 : r_idx;
        first_e = r_in_start ? 1'b0 : r_first;
        hdr_e   = r_in_start ? 1'b0 : r_hdr;

        wide   = {4'b0, buf_e} + ({16'b0, r_in_word} << held_e[3:0]);
        merged = wide[BUF_W-1:0];
        total  = {1'b0, held_e} + TOTAL_W'(WORD_W);

        n  = '0;
        ok = 1'b1;
        for (int k = 0; k < SLOTS; k++) begin
            n_res[k] = '0;
        end

        n_buf   = buf_e;
        n_held  = held_e;
        n_wpos  = wpos_e;
        n_idx   = idx_e;
        n_first = first_e;
        n_hdr   = hdr_e;

        if (wpos_e >= TRAILER_POS) begin
            n_res[0].item_kind        = KIND_TRAILER;
            n_res[0].frame_word       = r_in_word;
            n_res[0].channel_id       = r_in_word[WORD_W-1 -: CHAN_W];
            n_res[0].frame_has_header = hdr_e;
            n     = 2'd1;
            n_buf   = '0;
            n_held  = '0;
            n_wpos  = '0;
            n_idx   = '0;
            n_first = 1'b0;
            n_hdr   = 1'b0;
        end else begin
            n_wpos = wpos_e + 4'd1;
            for (int k = 0; k < SLOTS; k++) begin
                need  = TOTAL_W'(SAMPLE_W * (k + 1));
                pos   = {1'b0, idx_e} + TOTAL_W'(k);
                ok    = ok && (total >= need) && (pos < {1'b0, SAMPLES_PER_FRAME});
                s     = merged[SAMPLE_W*k +: SAMPLE_W];
                found = 1'b0;
                if (ok) begin
                    if (s == r_label_first) begin
                        n_first = 1'b1;
                    end else if (n_first && s == r_label_second) begin
                        found   = 1'b1;
                        n_hdr   = 1'b1;
                        n_first = 1'b0;
                    end else begin
                        n_first = 1'b0;
                    end
                    n_res[k].item_kind    = KIND_SAMPLE;
                    n_res[k].sample_value = s;
                    n_res[k].sample_index = pos[INDEX_W-1:0];
                    n_res[k].header_found = found;
                    n_res[k].header_start = found ? pos[INDEX_W-1:0] - 6'd1 : '0;
                    n = n + 2'd1;
                end
            end
            unique case (n)
                2'd0:    n_buf = merged;
                2'd1:    n_buf = merged >> SAMPLE_W;
                2'd2:    n_buf = merged >> (2 * SAMPLE_W);
                default: n_buf = merged >> (3 * SAMPLE_W);
            endcase
            n_held = HELD_W'(total - TOTAL_W'(SAMPLE_W) * {5'b0, n});
            n_idx  = idx_e + {4'b0, n};
        end
        n_cnt = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_held  <= '0;
            r_wpos  <= '0;
            r_idx   <= '0;
            r_first <= 1'b0;
            r_hdr   <= 1'b0;
        end else if (load) begin
            r_buf   <= n_buf;
            r_held  <= n_held;
            r_wpos  <= n_wpos;
            r_idx   <= n_idx;
            r_first <= n_first;
            r_hdr   <= n_hdr;
        end
    end

    // Result buffer, drained one word per cycle while the output is ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sel <= '0;
        end else if (load) begin
            r_cnt <= n_cnt;
            r_sel <= '0;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 2'd1;
            r_sel <= r_sel + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_res[k] <= n_res[k];
            end
        end
    end

    always_comb begin
        t_result cur;
        cur = (r_sel < SLOT_W'(SLOTS)) ? r_res[r_sel] : '0;
        o_out.valid            = (r_cnt != '0);
        o_out.item_kind        = cur.item_kind;
        o_out.sample_value     = cur.sample_value;
        o_out.sample_index     = cur.sample_index;
        o_out.header_found     = cur.header_found;
        o_out.header_start     = cur.header_start;
        o_out.frame_word       = cur.frame_word;
        o_out.channel_id       = cur.channel_id;
        o_out.frame_has_header = cur.frame_has_header;
        o_out.last             = (r_cnt == 2'd1);
    end

endmodule
`default_nettype wire
